// ----- hdl/bse_pkg.sv -----
`default_nettype none

package bse_pkg;

   // default size of the set, in elements
   localparam int UNIVERSE_BITS_DEF = 256;

   // field widths of one request and one response
   localparam int MODE_W = 3;
   localparam int ELEM_W = 8;
   localparam int POS_W  = 5;
   localparam int BYTE_W = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // response bit positions, lowest bit up
   localparam int RSP_MEMBER_LSB   = 0;
   localparam int RSP_SMALLEST_LSB = 1;
   localparam int RSP_LARGEST_LSB  = 9;
   localparam int RSP_EMPTY_LSB    = 17;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_TEST   = 3'd2,
      MODE_OR     = 3'd3,
      MODE_AND    = 3'd4
   } mode_type;

endpackage

`default_nettype wire

// ----- hdl/bitmap_set_engine_core.sv -----
`default_nettype none

// channel | dir | tdata fields, lowest bit up                               | tuser/tlast
// --------+-----+-----------------------------------------------------------+------------
// req_    | in  | mode[2:0] element_value[10:3] byte_position[15:11]        | none
//         |     | other_byte[23:16]                                         |
// rsp_    | out | is_member[0] smallest[8:1] largest[16:9] is_empty[17],    | none
//         |     | zero pad [23:18]                                          |
//
// one beat per clock sustained while rsp_ is not stalled; a beat goes from the input register
// into the response register when that register moves, and shows on rsp_ from there
// the single pass is the bitmap update followed by a binary tree of priority
// encoders (log2 of the bitmap size levels) that finds smallest and largest
// synchronous reset empties the set and both pipeline registers
// a stalled rsp_ holds its beat; req_ keeps taking one more beat into the input
// register and then waits until the response moves

module bitmap_set_engine_core #(
   parameter int UNIVERSE_BITS = bse_pkg::UNIVERSE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // mode, element_value, byte_position, other_byte
   input  wire  [bse_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // is_member, smallest, largest, is_empty, zero pad
   output logic [bse_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // bitmap geometry: element k sits at bit k of the flat set vector
   localparam int SET_BYTES = (UNIVERSE_BITS + 7) / 8;
   localparam int BITMAP_W  = SET_BYTES * 8;
   localparam int TREE_LVLS = $clog2(BITMAP_W);
   localparam int TREE_N    = 1 << TREE_LVLS;
   localparam int IDX_W     = TREE_LVLS;

   // bits that lie inside the universe; partial last byte stays clear
   localparam logic [BITMAP_W-1:0] UNIV_MASK =
      {BITMAP_W{1'b1}} >> (BITMAP_W - UNIVERSE_BITS);

   // input register
   logic                          in_valid_ff, in_valid_in;
   bse_pkg::mode_type             mode_ff, mode_in;
   logic [bse_pkg::ELEM_W-1:0]    elem_ff, elem_in;
   logic [bse_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [bse_pkg::BYTE_W-1:0]    other_ff, other_in;

   // set state
   logic [BITMAP_W-1:0]           set_ff, set_in;

   // response register
   logic                          out_valid_ff, out_valid_in;
   logic [bse_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic                          advance;
   logic                          move;

   // request lanes, other byte turned so its msb is the lowest element
   logic [bse_pkg::BYTE_W-1:0]    other_rev;
   logic [7:0]                    byte_shift;
   logic [BITMAP_W-1:0]           byte_lane;
   logic [BITMAP_W-1:0]           other_lane;
   logic [BITMAP_W-1:0]           elem_lane;
   logic [BITMAP_W-1:0]           set_next;

   // search tree, heap order: root at 1, leaves at TREE_N and up
   logic [TREE_N-1:0]             leaf_bits;
   logic                          node_v  [2*TREE_N];
   logic [IDX_W-1:0]              node_lo [2*TREE_N];
   logic [IDX_W-1:0]              node_hi [2*TREE_N];

   logic                          elem_in_range;
   logic                          member;
   logic                          found;
   logic [7:0]                    smallest;
   logic [7:0]                    largest;

   // handshake: the response register moves when empty or taken
   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // input register loads whenever it is free or draining
   always_comb begin
      in_valid_in = in_valid_ff;
      mode_in     = mode_ff;
      elem_in     = elem_ff;
      pos_in      = pos_ff;
      other_in    = other_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         mode_in     = bse_pkg::mode_type'(req_tdata[2:0]);
         elem_in     = req_tdata[10:3];
         pos_in      = req_tdata[15:11];
         other_in    = req_tdata[23:16];
      end
   end

   // byte lanes: a position beyond the bitmap shifts out to nothing
   always_comb begin
      for (int j = 0; j < bse_pkg::BYTE_W; j++) begin
         other_rev[j] = other_ff[bse_pkg::BYTE_W-1-j];
      end
   end

   assign byte_shift = {pos_ff, 3'b000};
   assign byte_lane  = BITMAP_W'(8'hFF) << byte_shift;
   assign other_lane = BITMAP_W'(other_rev) << byte_shift;
   assign elem_lane  = BITMAP_W'(1) << elem_ff;

   // set update
   always_comb begin
      case (mode_ff)
         bse_pkg::MODE_CLEAR:  set_next = '0;
         bse_pkg::MODE_INSERT: set_next = set_ff | (elem_lane & UNIV_MASK);
         bse_pkg::MODE_OR:     set_next = set_ff | (other_lane & UNIV_MASK);
         bse_pkg::MODE_AND:    set_next = set_ff & ~(byte_lane & ~other_lane);
         default:              set_next = set_ff;
      endcase
   end

   assign leaf_bits = TREE_N'(set_next);

   // node 0 is not part of the heap
   assign node_v[0]  = 1'b0;
   assign node_lo[0] = '0;
   assign node_hi[0] = '0;

   for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
      assign node_v[TREE_N+g]  = leaf_bits[g];
      assign node_lo[TREE_N+g] = IDX_W'(g);
      assign node_hi[TREE_N+g] = IDX_W'(g);
   end

   // left child holds the lower elements: min prefers left, max prefers right
   for (genvar n = 1; n < TREE_N; n++) begin : g_node
      assign node_v[n]  = node_v[2*n] | node_v[2*n+1];
      assign node_lo[n] = node_v[2*n]   ? node_lo[2*n]   : node_lo[2*n+1];
      assign node_hi[n] = node_v[2*n+1] ? node_hi[2*n+1] : node_hi[2*n];
   end

   assign found         = node_v[1];
   assign smallest      = found ? 8'(node_lo[1]) : 8'd0;
   assign largest       = found ? 8'(node_hi[1]) : 8'd0;
   assign elem_in_range = 32'(elem_ff) < 32'(UNIVERSE_BITS);
   assign member        = elem_in_range && leaf_bits[IDX_W'(elem_ff)];

   always_comb begin
      out_data_in                                = '0;
      out_data_in[bse_pkg::RSP_MEMBER_LSB]        = member;
      out_data_in[bse_pkg::RSP_SMALLEST_LSB +: 8] = smallest;
      out_data_in[bse_pkg::RSP_LARGEST_LSB +: 8]  = largest;
      out_data_in[bse_pkg::RSP_EMPTY_LSB]         = !found;
   end

   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;
   assign set_in       = move ? set_next : set_ff;

   // control and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         set_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         set_ff       <= set_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      elem_ff  <= elem_in;
      pos_ff   <= pos_in;
      other_ff <= other_in;
      if (move) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bse_checker.sv -----
`default_nettype none

module bse_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [bse_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // reset empties the pipeline
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // an empty set reports zero for smallest and largest
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[bse_pkg::RSP_EMPTY_LSB] |->
         rsp_tdata[bse_pkg::RSP_LARGEST_LSB+7:bse_pkg::RSP_SMALLEST_LSB] == 16'd0)
      else $error("empty set with nonzero bounds");

   // a member cannot be reported by an empty set
   a_member_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[bse_pkg::RSP_MEMBER_LSB] |->
         !rsp_tdata[bse_pkg::RSP_EMPTY_LSB])
      else $error("member reported in empty set");

   // request side keeps moving when the response side is free
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with response side idle");

endmodule

bind bitmap_set_engine_core bse_checker u_bse_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

   // set size at the default build of the core
   localparam int UNIVERSE = bse_pkg::UNIVERSE_BITS_DEF;

   // mode codes the core leaves unused: the set stays as it is, a response still comes back
   localparam logic [bse_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [bse_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [bse_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

   localparam int LONG_HOLD      = 150;  // receiver hold-off, in cycles, during the pressure test
   localparam int DRAIN_CYCLES   = 8;    // quiet cycles after the last response, to catch strays
   localparam int FIRST_MIX      = 800;
   localparam int SECOND_MIX     = 700;
   localparam int PRESSURE_BEATS = 80;

   // one response beat, unpacked
   typedef struct packed {
      logic                       is_member;
      logic [bse_pkg::ELEM_W-1:0] smallest;
      logic [bse_pkg::ELEM_W-1:0] largest;
      logic                       is_empty;
   } set_report_type;

   // every input is known from time zero
   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // mode, element_value, byte_position, other_byte
   logic [bse_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // is_member, smallest, largest, is_empty, pad
   logic [bse_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // shadow copy of the membership bitmap, indexed by element
   bit             shadow_set [UNIVERSE];
   // reports owed by the core, oldest first
   set_report_type expected_reports [$];
   int             mismatch_count = 0;

   // steady = no gaps on either side
   bit steady     = 1'b0;
   // long hold-off handshake between the test tasks and the receiver process
   int hold_asked = 0;
   int hold_done  = 0;
   int stall_left = 0;

   bitmap_set_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one operation to the shadow set and work out the report that follows it
   function automatic set_report_type advance_shadow_set(
         logic [bse_pkg::MODE_W-1:0] mode,
         logic [bse_pkg::ELEM_W-1:0] elem,
         logic [bse_pkg::POS_W-1:0]  pos,
         logic [bse_pkg::BYTE_W-1:0] other);
      set_report_type rpt;
      int             k;
      bit             found;
      rpt   = '0;
      found = 1'b0;
      case (mode)
         bse_pkg::MODE_CLEAR: foreach (shadow_set[i]) shadow_set[i] = 1'b0;
         bse_pkg::MODE_INSERT: if (int'(elem) < UNIVERSE) shadow_set[elem] = 1'b1;
         bse_pkg::MODE_OR, bse_pkg::MODE_AND: begin
            // msb of the byte is the lowest element; bits past the set are dropped
            for (int b = 0; b < 8; b++) begin
               k = int'(pos) * 8 + b;
               if (k < UNIVERSE) begin
                  if (mode == bse_pkg::MODE_OR) shadow_set[k] = shadow_set[k] | other[7-b];
                  else shadow_set[k] = shadow_set[k] & other[7-b];
               end
            end
         end
         default: ;
      endcase
      // lowest hit sets smallest once, the last hit leaves largest
      for (int i = 0; i < UNIVERSE; i++) begin
         if (shadow_set[i]) begin
            if (!found) rpt.smallest = bse_pkg::ELEM_W'(i);
            rpt.largest = bse_pkg::ELEM_W'(i);
            found = 1'b1;
         end
      end
      rpt.is_empty  = !found;
      rpt.is_member = (int'(elem) < UNIVERSE) && shadow_set[elem];
      return rpt;
   endfunction

   // idle length for either side: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one request beat, record its report once the core takes it
   task automatic send_beat(input logic [bse_pkg::MODE_W-1:0] mode,
                            input logic [bse_pkg::ELEM_W-1:0] elem,
                            input logic [bse_pkg::POS_W-1:0]  pos,
                            input logic [bse_pkg::BYTE_W-1:0] other);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {other, pos, elem, mode};
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(advance_shadow_set(mode, elem, pos, other));
   endtask

   // receiver: random stalls, plus the long hold-off when a test asks for one
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done  = hold_asked;
         stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker: every accepted beat against the oldest owed report
   always @(posedge clock) begin
      set_report_type want;
      set_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.is_member = rsp_tdata[bse_pkg::RSP_MEMBER_LSB];
         got.smallest  = rsp_tdata[bse_pkg::RSP_SMALLEST_LSB +: bse_pkg::ELEM_W];
         got.largest   = rsp_tdata[bse_pkg::RSP_LARGEST_LSB +: bse_pkg::ELEM_W];
         got.is_empty  = rsp_tdata[bse_pkg::RSP_EMPTY_LSB];
         if (expected_reports.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (got.is_member !== want.is_member) begin
               $error("is_member: expected %0d, got %0d", want.is_member, got.is_member);
               mismatch_count++;
            end
            if (got.smallest !== want.smallest) begin
               $error("smallest: expected %0d, got %0d", want.smallest, got.smallest);
               mismatch_count++;
            end
            if (got.largest !== want.largest) begin
               $error("largest: expected %0d, got %0d", want.largest, got.largest);
               mismatch_count++;
            end
            if (got.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
               mismatch_count++;
            end
         end
      end
   end

   // empty set straight out of reset: both ends report 0
   task automatic check_reset_state();
      send_beat(bse_pkg::MODE_TEST, 8'd0, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_TEST, 8'd255, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
   endtask

   // each mode at the edges of the element range and of the bitmap
   task automatic check_each_mode();
      send_beat(bse_pkg::MODE_INSERT, 8'd255, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_TEST, 8'd255, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_INSERT, 8'd0, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_TEST, 8'd128, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      // elements 128 and 135, both ends of one byte
      send_beat(bse_pkg::MODE_OR, 8'd128, 5'd16, 8'h81);
      // drop element 0, smallest moves up to 128
      send_beat(bse_pkg::MODE_AND, 8'd0, 5'd0, 8'h00);
      send_beat(bse_pkg::MODE_AND, 8'd255, 5'd31, 8'hFF);
      // drop element 255, largest falls back to 135
      send_beat(bse_pkg::MODE_AND, 8'd255, 5'd31, 8'hFE);
      send_beat(bse_pkg::MODE_OR, 8'd7, 5'd0, 8'hFF);
      send_beat(bse_pkg::MODE_OR, 8'd248, 5'd31, 8'hFF);
      send_beat(bse_pkg::MODE_INSERT, 8'd8, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_CLEAR, 8'd7, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(bse_pkg::MODE_TEST, 8'd7, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      // single element at the very top
      send_beat(bse_pkg::MODE_OR, 8'd255, 5'd31, 8'h01);
      // and back to empty through an and
      send_beat(bse_pkg::MODE_AND, 8'd255, 5'd31, 8'h00);
      send_beat(bse_pkg::MODE_INSERT, 8'd8, bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
   endtask

   // unused mode codes leave the set alone but still answer
   task automatic check_spare_modes();
      send_beat(MODE_SPARE_A, 8'd8, bse_pkg::POS_W'($urandom), bse_pkg::BYTE_W'($urandom));
      send_beat(MODE_SPARE_B, bse_pkg::ELEM_W'($urandom), bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
      send_beat(MODE_SPARE_C, bse_pkg::ELEM_W'($urandom), bse_pkg::POS_W'($urandom),
                bse_pkg::BYTE_W'($urandom));
   endtask

   // random operations; rare clears let the set fill up between them
   task automatic check_random_mix(input int beats);
      logic [bse_pkg::MODE_W-1:0] mode;
      logic [bse_pkg::ELEM_W-1:0] elem;
      logic [bse_pkg::POS_W-1:0]  pos;
      logic [bse_pkg::BYTE_W-1:0] other;
      int                         r;
      for (int n = 0; n < beats; n++) begin
         // swap between gappy and gap-free stretches
         if (n % 128 == 0) steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 2)       mode = bse_pkg::MODE_CLEAR;
         else if (r < 35) mode = bse_pkg::MODE_INSERT;
         else if (r < 60) mode = bse_pkg::MODE_TEST;
         else if (r < 76) mode = bse_pkg::MODE_OR;
         else if (r < 95) mode = bse_pkg::MODE_AND;
         else             mode = MODE_SPARE_A + bse_pkg::MODE_W'($urandom_range(0, 2));
         elem  = bse_pkg::ELEM_W'($urandom);
         pos   = bse_pkg::POS_W'($urandom);
         other = bse_pkg::BYTE_W'($urandom);
         send_beat(mode, elem, pos, other);
      end
      steady = 1'b0;
   endtask

   // receiver holds off for a long stretch while beats keep coming, so req_ stalls
   task automatic check_backpressure();
      steady = 1'b1;
      hold_asked++;
      for (int n = 0; n < PRESSURE_BEATS; n++) begin
         send_beat((n % 2 == 0) ? bse_pkg::MODE_INSERT : bse_pkg::MODE_TEST,
                   bse_pkg::ELEM_W'($urandom), bse_pkg::POS_W'($urandom),
                   bse_pkg::BYTE_W'($urandom));
      end
      steady = 1'b0;
   endtask

   // wait for every owed report, then a quiet spell to catch strays
   task automatic drain_responses();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      check_reset_state();
      check_each_mode();
      check_spare_modes();
      check_random_mix(FIRST_MIX);
      check_backpressure();
      check_random_mix(SECOND_MIX);
      req_tvalid <= 1'b0;
      drain_responses();
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
